### rtl/overwriting_ring_buffer_mean_top_defines.svh
// Assertion helpers for the ring buffer mean block.
// They expect clk and rst_n to be visible where they are used.
`ifndef OVERWRITING_RING_BUFFER_MEAN_TOP_DEFINES_SVH
`define OVERWRITING_RING_BUFFER_MEAN_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ORBM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ORBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/orbm_pkg.sv
package orbm_pkg;

    // Built number of slots and the widths that follow from it.
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Sample and running sum widths. The sum holds up to DEPTH full-scale samples.
    localparam int DATA_W = 32;
    localparam int SUM_W  = DATA_W + ADDR_W;

    // Size register as seen on the configuration channel.
    localparam int CFG_W      = 11;
    localparam int SIZE_RESET = 1024;

    // Request commands.
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

### rtl/orbm_div.sv
// Bit-serial signed divider: one quotient bit per cycle, truncating toward zero.
module orbm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  orbm_pkg::sum_t               dividend,
    input  logic [orbm_pkg::CNT_W-1:0]   divisor,
    output logic                         done,
    output orbm_pkg::sample_t            quotient
);

    localparam int STEP_W = $clog2(orbm_pkg::SUM_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [STEP_W-1:0]             step_reg;
    logic                          neg_reg;
    logic [orbm_pkg::SUM_W-1:0]    quo_reg;
    logic [orbm_pkg::CNT_W-1:0]    rem_reg;
    logic [orbm_pkg::CNT_W-1:0]    div_reg;

    logic [orbm_pkg::SUM_W-1:0]    mag;
    logic [orbm_pkg::CNT_W:0]      trial;
    logic [orbm_pkg::CNT_W:0]      diff;
    logic                          take;
    logic [orbm_pkg::CNT_W-1:0]    rem_next;
    logic [orbm_pkg::DATA_W-1:0]   quo_low;

    assign mag      = dividend[orbm_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
    assign trial    = {rem_reg, quo_reg[orbm_pkg::SUM_W-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign take     = (trial >= {1'b0, div_reg});
    assign rem_next = take ? diff[orbm_pkg::CNT_W-1:0] : trial[orbm_pkg::CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(orbm_pkg::SUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= dividend[orbm_pkg::SUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[orbm_pkg::SUM_W-2:0], take};
            rem_reg <= rem_next;
        end
    end

    // The magnitude of a valid quotient never exceeds 2^31, so the low word is enough.
    assign quo_low  = quo_reg[orbm_pkg::DATA_W-1:0];
    assign quotient = neg_reg ? (~quo_low + 1'b1) : quo_low;
    assign done     = done_reg;

endmodule

### rtl/overwriting_ring_buffer_mean_top.sv
// Overwriting ring buffer of signed 32-bit samples with a running mean.
// Requests enter on the s_axis channel: tuser carries the command (write, read
// or fill) and tdata the sample. Each request produces exactly one result on
// the m_axis channel with the popped sample, read_ok in tuser, the empty and
// full flags, the entry count and the mean (zero unless the buffer is full).
// The cfg channel sets the number of slots in use and empties the buffer.
// Requests are handled one at a time. A write, a read or an unknown command
// goes through the read, update and sum states; when the buffer ends up full,
// the running sum then goes through a bit-serial divider that retires one
// quotient bit per cycle over 42 bits before the result is registered.
// A fill writes one slot per cycle through the sample memory's single write
// port and then sends its sum through the same divider.
// The next request may be taken on the cycle after a result is registered.
// After reset the size is 1024 and the buffer is empty; no clearing pass runs,
// since the value of a slot is only ever used after it has been written.
// The result sits in an output register. While the receiver stalls, the next
// request is still accepted and processed, and only its result waits for the
// output register to free up.
module overwriting_ring_buffer_mean_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // [31:0] sample
    input  logic [1:0]                    s_axis_tuser,  // [1:0] command
    // Result channel.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] popped sample, [32] is_empty, [33] is_full, [44:34] entry_count,
    // [76:45] mean_value, [79:77] zero
    output logic [79:0]                   m_axis_tdata,
    output logic [0:0]                    m_axis_tuser,  // [0] read_ok
    // Size configuration.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [orbm_pkg::CFG_W-1:0]    cfg_data
);

    localparam int ADDR_W = orbm_pkg::ADDR_W;
    localparam int CNT_W  = orbm_pkg::CNT_W;
    localparam int DATA_W = orbm_pkg::DATA_W;
    localparam int SUM_W  = orbm_pkg::SUM_W;
    localparam int RES_W  = 2 * DATA_W + 2 + orbm_pkg::CFG_W;
    localparam int PAD_W  = 80 - RES_W;

    localparam logic [CNT_W-1:0] RESET_SIZE =
        CNT_W'((orbm_pkg::DEPTH < orbm_pkg::SIZE_RESET) ? orbm_pkg::DEPTH
                                                        : orbm_pkg::SIZE_RESET);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_START  = 3'd5;
    localparam logic [2:0] ST_DIV    = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    // Next slot index, wrapping at the configured size.
    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] p,
                                                  input logic [CNT_W-1:0]  sz);
        logic [CNT_W-1:0] n;
        n = CNT_W'(p) + 1'b1;
        return (n >= sz) ? '0 : n[ADDR_W-1:0];
    endfunction

    // A size of zero means one slot; an oversize value saturates to the depth.
    function automatic logic [CNT_W-1:0] eff_size(input logic [orbm_pkg::CFG_W-1:0] v);
        logic [CNT_W-1:0] s;
        if (v == '0)
            s = CNT_W'(1);
        else if (int'(v) > orbm_pkg::DEPTH)
            s = CNT_W'(orbm_pkg::DEPTH);
        else
            s = CNT_W'(v);
        return s;
    endfunction

    // Sample memory.
    orbm_pkg::sample_t mem [orbm_pkg::DEPTH];
    orbm_pkg::sample_t rdata_reg;

    // Control state.
    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              m_valid_reg, m_valid_next;

    // Payload of the request in flight.
    orbm_pkg::sum_t             sum_reg, sum_next;
    logic [orbm_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    orbm_pkg::sample_t          smp_reg, smp_next;
    logic signed [DATA_W:0]     delta_reg, delta_next;
    orbm_pkg::sample_t          rv_reg, rv_next;
    logic                       ok_reg, ok_next;
    orbm_pkg::sample_t          mean_reg, mean_next;

    // Output register.
    orbm_pkg::sample_t          out_rv_reg, out_mean_reg;
    logic                       out_ok_reg, out_empty_reg, out_full_reg;
    logic [orbm_pkg::CFG_W-1:0] out_count_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic              out_load;
    logic              div_start;
    logic              div_done;
    orbm_pkg::sample_t div_quotient;

    orbm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (size_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign cfg_ready     = (state_reg == ST_IDLE);
    // A configuration write takes precedence over a request in the same cycle.
    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_valid;

    // A read pops the oldest slot; a write needs the slot it may overwrite.
    assign mem_raddr = (cmd_reg == orbm_pkg::CMD_READ) ? tail_reg : head_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= smp_reg;
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next   = state_reg;
        size_next    = size_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        cmd_next     = cmd_reg;
        smp_next     = smp_reg;
        delta_next   = delta_reg;
        rv_next      = rv_reg;
        ok_next      = ok_reg;
        mean_next    = mean_reg;
        mem_we       = 1'b0;
        mem_waddr    = head_reg;
        div_start    = 1'b0;
        out_load     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    size_next  = eff_size(cfg_data);
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                    sum_next   = '0;
                end
                else if (s_axis_tvalid)
                begin
                    cmd_next = s_axis_tuser;
                    smp_next = s_axis_tdata;
                    rv_next  = '0;
                    ok_next  = 1'b0;
                    if (s_axis_tuser == orbm_pkg::CMD_FILL)
                    begin
                        fill_next  = '0;
                        sum_next   = '0;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_UPDATE;
            end

            ST_UPDATE:
            begin
                delta_next = '0;
                case (cmd_reg)
                    orbm_pkg::CMD_WRITE:
                    begin
                        mem_we    = 1'b1;
                        head_next = advance(head_reg, size_reg);
                        if (count_reg >= size_reg)
                        begin
                            // Full: the oldest entry drops out of the sum.
                            delta_next = {smp_reg[DATA_W-1], smp_reg}
                                       - {rdata_reg[DATA_W-1], rdata_reg};
                            tail_next  = advance(tail_reg, size_reg);
                        end
                        else
                        begin
                            delta_next = {smp_reg[DATA_W-1], smp_reg};
                            count_next = count_reg + 1'b1;
                        end
                    end
                    orbm_pkg::CMD_READ:
                    begin
                        if (count_reg != '0)
                        begin
                            rv_next    = rdata_reg;
                            ok_next    = 1'b1;
                            delta_next = -{rdata_reg[DATA_W-1], rdata_reg};
                            count_next = count_reg - 1'b1;
                            tail_next  = advance(tail_reg, size_reg);
                        end
                    end
                    default:
                    begin
                        delta_next = '0;
                    end
                endcase
                state_next = ST_SUM;
            end

            ST_SUM:
            begin
                sum_next  = sum_reg + {{(SUM_W-DATA_W-1){delta_reg[DATA_W]}}, delta_reg};
                mean_next = '0;
                state_next = (count_reg == size_reg) ? ST_START : ST_DONE;
            end

            ST_FILL:
            begin
                // One slot per cycle; the sum ends as sample times size.
                mem_we    = 1'b1;
                mem_waddr = fill_reg[ADDR_W-1:0];
                sum_next  = sum_reg + {{(SUM_W-DATA_W){smp_reg[DATA_W-1]}}, smp_reg};
                fill_next = fill_reg + 1'b1;
                if ((fill_reg + 1'b1) == size_reg)
                begin
                    tail_next  = head_reg;
                    count_next = size_reg;
                    state_next = ST_START;
                end
            end

            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    mean_next  = div_quotient;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        if (out_load)
            m_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            size_reg    <= RESET_SIZE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        smp_reg   <= smp_next;
        delta_reg <= delta_next;
        rv_reg    <= rv_next;
        ok_reg    <= ok_next;
        mean_reg  <= mean_next;
        if (out_load)
        begin
            out_rv_reg    <= rv_reg;
            out_ok_reg    <= ok_reg;
            out_empty_reg <= (count_reg == '0);
            out_full_reg  <= (count_reg == size_reg);
            out_count_reg <= orbm_pkg::CFG_W'(count_reg);
            out_mean_reg  <= mean_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_mean_reg, out_count_reg,
                            out_full_reg, out_empty_reg, out_rv_reg};
    assign m_axis_tuser  = out_ok_reg;

endmodule

### rtl/orbm_checker.sv
`include "overwriting_ring_buffer_mean_top_defines.svh"

// Port-level checks for the ring buffer mean block.
module orbm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A stalled result stays put.
    `ORBM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // The empty flag agrees with the entry count.
    `ORBM_ASSERT_IMPLY(a_empty_count, m_axis_tvalid, m_axis_tdata[32] == (m_axis_tdata[44:34] == 11'd0), "empty flag disagrees with count")

    // The mean is zero unless the buffer is full.
    `ORBM_ASSERT_IMPLY(a_mean_zero, m_axis_tvalid && !m_axis_tdata[33], m_axis_tdata[76:45] == 32'd0, "mean nonzero while not full")

    // Without a successful read the popped value is zero.
    `ORBM_ASSERT_IMPLY(a_read_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[31:0] == 32'd0, "read value nonzero without read_ok")

    // Requests are handled one at a time.
    `ORBM_ASSERT_NEXT(a_one_request, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")

endmodule

bind overwriting_ring_buffer_mean_top orbm_checker u_orbm_checker (.*);
